// ===== sv/rcc_pkg.sv =====
// Shared definitions for the rectangle/circle collision pipeline.
// Holds widths, shape-kind codes and the control word passed between stages.
package rcc_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int LAYER_BITS         = 32;

   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   // Per-item control flags that travel alongside the geometry
   typedef struct packed {
      logic layer_ok;   // masks share a bit or are equal
      logic rect_pair;  // both shapes are rectangles
      logic point_b;    // B is the point side of the clamp, A the box side
      logic rect_hit;   // strict interval overlap on both axes
   } ctl_type;

endpackage

// ===== sv/rcc_prep.sv =====
// Stage one: layer match, role selection, box far edges and combined radius.
// Depends on rcc_pkg.
module rcc_prep import rcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  logic                    kind_a,
   input  logic [LAYER_BITS-1:0]   layers_a,
   input  logic [COORD_BITS-1:0]   pos_x_a,
   input  logic [COORD_BITS-1:0]   pos_y_a,
   input  logic [COORD_BITS-2:0]   extent_w_a,
   input  logic [COORD_BITS-2:0]   extent_h_a,
   input  logic                    kind_b,
   input  logic [LAYER_BITS-1:0]   layers_b,
   input  logic [COORD_BITS-1:0]   pos_x_b,
   input  logic [COORD_BITS-1:0]   pos_y_b,
   input  logic [COORD_BITS-2:0]   extent_w_b,
   input  logic [COORD_BITS-2:0]   extent_h_b,
   output logic                    out_valid,
   input  logic                    out_stall,
   output ctl_type                 out_ctl,
   output logic [COORD_BITS-1:0]   out_xa,
   output logic [COORD_BITS-1:0]   out_ya,
   output logic [COORD_BITS-1:0]   out_xb,
   output logic [COORD_BITS-1:0]   out_yb,
   output logic [COORD_BITS:0]     out_end_xa,
   output logic [COORD_BITS:0]     out_end_ya,
   output logic [COORD_BITS:0]     out_end_xb,
   output logic [COORD_BITS:0]     out_end_yb,
   output logic [COORD_BITS-1:0]   out_rad
);

   localparam int CW = COORD_BITS;
   localparam int EW = COORD_BITS - 1;

   logic                 valid_ff, valid_in;
   ctl_type              ctl_ff, ctl_in;
   logic [CW-1:0]        xa_ff, ya_ff, xb_ff, yb_ff;
   logic [CW:0]          end_xa_ff, end_ya_ff, end_xb_ff, end_yb_ff;
   logic [CW:0]          end_xa_in, end_ya_in, end_xb_in, end_yb_in;
   logic [CW-1:0]        rad_ff, rad_in;
   logic                 circ_a, circ_b;
   logic [EW-1:0]        wa_eff, ha_eff, wb_eff, hb_eff;

   assign circ_a = (kind_a == KIND_CIRCLE);
   assign circ_b = (kind_b == KIND_CIRCLE);

   // A circle acts as a single point, so its far edge equals its centre
   assign wa_eff = circ_a ? '0 : extent_w_a;
   assign ha_eff = circ_a ? '0 : extent_h_a;
   assign wb_eff = circ_b ? '0 : extent_w_b;
   assign hb_eff = circ_b ? '0 : extent_h_b;

   always_comb begin
      end_xa_in = {pos_x_a[CW-1], pos_x_a} + {2'b00, wa_eff};
      end_ya_in = {pos_y_a[CW-1], pos_y_a} + {2'b00, ha_eff};
      end_xb_in = {pos_x_b[CW-1], pos_x_b} + {2'b00, wb_eff};
      end_yb_in = {pos_y_b[CW-1], pos_y_b} + {2'b00, hb_eff};
   end

   // Radius: sum for two circles, else the single circle's, else extent_w_b
   always_comb begin
      if (circ_a && circ_b) begin
         rad_in = {1'b0, extent_w_a} + {1'b0, extent_w_b};
      end else if (circ_a) begin
         rad_in = {1'b0, extent_w_a};
      end else begin
         rad_in = {1'b0, extent_w_b};
      end
   end

   always_comb begin
      ctl_in.layer_ok  = (|(layers_a & layers_b)) || (layers_a == layers_b);
      ctl_in.rect_pair = !circ_a && !circ_b;
      ctl_in.point_b   = circ_b;
      ctl_in.rect_hit  = 1'b0;
   end

   // Hold while the next stage is full and stalled
   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         ctl_ff    <= ctl_in;
         xa_ff     <= pos_x_a;
         ya_ff     <= pos_y_a;
         xb_ff     <= pos_x_b;
         yb_ff     <= pos_y_b;
         end_xa_ff <= end_xa_in;
         end_ya_ff <= end_ya_in;
         end_xb_ff <= end_xb_in;
         end_yb_ff <= end_yb_in;
         rad_ff    <= rad_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_ctl    = ctl_ff;
   assign out_xa     = xa_ff;
   assign out_ya     = ya_ff;
   assign out_xb     = xb_ff;
   assign out_yb     = yb_ff;
   assign out_end_xa = end_xa_ff;
   assign out_end_ya = end_ya_ff;
   assign out_end_xb = end_xb_ff;
   assign out_end_yb = end_yb_ff;
   assign out_rad    = rad_ff;

endmodule

// ===== sv/rcc_clamp.sv =====
// Stage two: rectangle interval overlap, and clamp of the point onto the box.
// Depends on rcc_pkg.
module rcc_clamp import rcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  ctl_type                 in_ctl,
   input  logic [COORD_BITS-1:0]   in_xa,
   input  logic [COORD_BITS-1:0]   in_ya,
   input  logic [COORD_BITS-1:0]   in_xb,
   input  logic [COORD_BITS-1:0]   in_yb,
   input  logic [COORD_BITS:0]     in_end_xa,
   input  logic [COORD_BITS:0]     in_end_ya,
   input  logic [COORD_BITS:0]     in_end_xb,
   input  logic [COORD_BITS:0]     in_end_yb,
   input  logic [COORD_BITS-1:0]   in_rad,
   output logic                    out_valid,
   input  logic                    out_stall,
   output ctl_type                 out_ctl,
   output logic [COORD_BITS-1:0]   out_mag_x,
   output logic [COORD_BITS-1:0]   out_mag_y,
   output logic [COORD_BITS-1:0]   out_rad
);

   localparam int CW = COORD_BITS;

   logic            valid_ff, valid_in;
   ctl_type         ctl_ff, ctl_in;
   logic [CW-1:0]   mag_x_ff, mag_y_ff, rad_ff;
   logic [CW-1:0]   mag_x_in, mag_y_in;
   logic [CW:0]     xa_e, ya_e, xb_e, yb_e;
   logic            ovl_x, ovl_y;
   logic [CW+1:0]   lo_x, hi_x, pt_x, lo_y, hi_y, pt_y;
   logic [CW+1:0]   dlo_x, dhi_x, dlo_y, dhi_y;

   assign xa_e = {in_xa[CW-1], in_xa};
   assign ya_e = {in_ya[CW-1], in_ya};
   assign xb_e = {in_xb[CW-1], in_xb};
   assign yb_e = {in_yb[CW-1], in_yb};

   // Strict overlap: each start lies before both ends (also rejects zero extents)
   always_comb begin
      ovl_x = ($signed(xa_e) < $signed(in_end_xa)) && ($signed(xa_e) < $signed(in_end_xb)) &&
              ($signed(xb_e) < $signed(in_end_xa)) && ($signed(xb_e) < $signed(in_end_xb));
      ovl_y = ($signed(ya_e) < $signed(in_end_ya)) && ($signed(ya_e) < $signed(in_end_yb)) &&
              ($signed(yb_e) < $signed(in_end_ya)) && ($signed(yb_e) < $signed(in_end_yb));
   end

   // Pick the box side and the point side
   always_comb begin
      if (in_ctl.point_b) begin
         lo_x = {xa_e[CW], xa_e};
         hi_x = {in_end_xa[CW], in_end_xa};
         pt_x = {xb_e[CW], xb_e};
         lo_y = {ya_e[CW], ya_e};
         hi_y = {in_end_ya[CW], in_end_ya};
         pt_y = {yb_e[CW], yb_e};
      end else begin
         lo_x = {xb_e[CW], xb_e};
         hi_x = {in_end_xb[CW], in_end_xb};
         pt_x = {xa_e[CW], xa_e};
         lo_y = {yb_e[CW], yb_e};
         hi_y = {in_end_yb[CW], in_end_yb};
         pt_y = {ya_e[CW], ya_e};
      end
   end

   // Distance from the point to the clamped point, as a magnitude
   always_comb begin
      dlo_x = lo_x - pt_x;
      dhi_x = pt_x - hi_x;
      dlo_y = lo_y - pt_y;
      dhi_y = pt_y - hi_y;
      if (!dlo_x[CW+1] && (|dlo_x)) begin
         mag_x_in = dlo_x[CW-1:0];
      end else if (!dhi_x[CW+1] && (|dhi_x)) begin
         mag_x_in = dhi_x[CW-1:0];
      end else begin
         mag_x_in = '0;
      end
      if (!dlo_y[CW+1] && (|dlo_y)) begin
         mag_y_in = dlo_y[CW-1:0];
      end else if (!dhi_y[CW+1] && (|dhi_y)) begin
         mag_y_in = dhi_y[CW-1:0];
      end else begin
         mag_y_in = '0;
      end
   end

   always_comb begin
      ctl_in          = in_ctl;
      ctl_in.rect_hit = ovl_x && ovl_y;
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         ctl_ff   <= ctl_in;
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         rad_ff   <= in_rad;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_mag_x = mag_x_ff;
   assign out_mag_y = mag_y_ff;
   assign out_rad   = rad_ff;

endmodule

// ===== sv/rcc_square.sv =====
// Stage three: square the two distance magnitudes and the radius.
// Depends on rcc_pkg.
module rcc_square import rcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  ctl_type                   in_ctl,
   input  logic [COORD_BITS-1:0]     in_mag_x,
   input  logic [COORD_BITS-1:0]     in_mag_y,
   input  logic [COORD_BITS-1:0]     in_rad,
   output logic                      out_valid,
   input  logic                      out_stall,
   output ctl_type                   out_ctl,
   output logic [2*COORD_BITS-1:0]   out_sq_x,
   output logic [2*COORD_BITS-1:0]   out_sq_y,
   output logic [2*COORD_BITS-1:0]   out_sq_r
);

   localparam int CW = COORD_BITS;
   localparam int PW = 2 * COORD_BITS;

   logic            valid_ff, valid_in;
   ctl_type         ctl_ff;
   logic [PW-1:0]   sq_x_ff, sq_y_ff, sq_r_ff;
   logic [PW-1:0]   sq_x_in, sq_y_in, sq_r_in;

   // Three independent CW x CW unsigned squares
   always_comb begin
      sq_x_in = {{CW{1'b0}}, in_mag_x} * {{CW{1'b0}}, in_mag_x};
      sq_y_in = {{CW{1'b0}}, in_mag_y} * {{CW{1'b0}}, in_mag_y};
      sq_r_in = {{CW{1'b0}}, in_rad}   * {{CW{1'b0}}, in_rad};
   end

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         ctl_ff  <= in_ctl;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_r_ff <= sq_r_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_sq_x  = sq_x_ff;
   assign out_sq_y  = sq_y_ff;
   assign out_sq_r  = sq_r_ff;

endmodule

// ===== sv/rcc_compare.sv =====
// Stage four: squared-distance compare and the registered hit result.
// Depends on rcc_pkg.
module rcc_compare import rcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_stall,
   input  ctl_type                   in_ctl,
   input  logic [2*COORD_BITS-1:0]   in_sq_x,
   input  logic [2*COORD_BITS-1:0]   in_sq_y,
   input  logic [2*COORD_BITS-1:0]   in_sq_r,
   output logic                      out_valid,
   input  logic                      out_stall,
   output logic                      out_hit
);

   localparam int PW = 2 * COORD_BITS;

   logic            valid_ff, valid_in;
   logic            hit_ff, hit_in;
   logic [PW:0]     dist_sq;
   logic            in_reach;

   // Inclusive test: touching shapes count as a hit
   assign dist_sq  = {1'b0, in_sq_x} + {1'b0, in_sq_y};
   assign in_reach = (dist_sq <= {1'b0, in_sq_r});

   assign hit_in = in_ctl.layer_ok && (in_ctl.rect_pair ? in_ctl.rect_hit : in_reach);

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         hit_ff <= hit_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;

endmodule

// ===== sv/rect_circle_collision_test.sv =====
// Collision test for one pair of shapes (rectangle or circle) per transfer.
// Request channel (req_*): two shape descriptions, each with kind, layer
//   mask, position and extents; a circle uses extent_w as its radius.
// Response channel (rsp_*): one hit flag per request, in request order.
// Both channels move a transfer on a clock edge where valid is high and
//   stall is low.
// Each request passes the stage registers prep, clamp and square in order,
//   then the output register, before its response becomes valid.
// Throughput: one pair per cycle while req_stall is low; the four register
//   stages each advance independently, so bubbles close up and req_stall
//   rises only when all stages hold data and rsp_stall is high.
// A stall on the response side holds rsp_hit steady and backs the pipeline
//   up stage by stage; nothing is dropped or repeated.
// Reset (synchronous, active high) clears every stage valid bit; items in
//   flight are discarded. There is no configuration and no state between
//   items.
// Depends on rcc_pkg and the rcc_* stage modules.
module rect_circle_collision_test import rcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind_a,
   input  logic [LAYER_BITS-1:0]   req_layers_a,
   input  logic [COORD_BITS-1:0]   req_pos_x_a,
   input  logic [COORD_BITS-1:0]   req_pos_y_a,
   input  logic [COORD_BITS-2:0]   req_extent_w_a,
   input  logic [COORD_BITS-2:0]   req_extent_h_a,
   input  logic                    req_kind_b,
   input  logic [LAYER_BITS-1:0]   req_layers_b,
   input  logic [COORD_BITS-1:0]   req_pos_x_b,
   input  logic [COORD_BITS-1:0]   req_pos_y_b,
   input  logic [COORD_BITS-2:0]   req_extent_w_b,
   input  logic [COORD_BITS-2:0]   req_extent_h_b,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit
);

   localparam int CW = COORD_BITS;
   localparam int PW = 2 * COORD_BITS;

   logic            s1_valid, s1_stall;
   ctl_type         s1_ctl;
   logic [CW-1:0]   s1_xa, s1_ya, s1_xb, s1_yb, s1_rad;
   logic [CW:0]     s1_end_xa, s1_end_ya, s1_end_xb, s1_end_yb;

   logic            s2_valid, s2_stall;
   ctl_type         s2_ctl;
   logic [CW-1:0]   s2_mag_x, s2_mag_y, s2_rad;

   logic            s3_valid, s3_stall;
   ctl_type         s3_ctl;
   logic [PW-1:0]   s3_sq_x, s3_sq_y, s3_sq_r;

   rcc_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .kind_a     (req_kind_a),
      .layers_a   (req_layers_a),
      .pos_x_a    (req_pos_x_a),
      .pos_y_a    (req_pos_y_a),
      .extent_w_a (req_extent_w_a),
      .extent_h_a (req_extent_h_a),
      .kind_b     (req_kind_b),
      .layers_b   (req_layers_b),
      .pos_x_b    (req_pos_x_b),
      .pos_y_b    (req_pos_y_b),
      .extent_w_b (req_extent_w_b),
      .extent_h_b (req_extent_h_b),
      .out_valid  (s1_valid),
      .out_stall  (s1_stall),
      .out_ctl    (s1_ctl),
      .out_xa     (s1_xa),
      .out_ya     (s1_ya),
      .out_xb     (s1_xb),
      .out_yb     (s1_yb),
      .out_end_xa (s1_end_xa),
      .out_end_ya (s1_end_ya),
      .out_end_xb (s1_end_xb),
      .out_end_yb (s1_end_yb),
      .out_rad    (s1_rad)
   );

   rcc_clamp #(.COORD_BITS(COORD_BITS)) u_clamp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_ctl    (s1_ctl),
      .in_xa     (s1_xa),
      .in_ya     (s1_ya),
      .in_xb     (s1_xb),
      .in_yb     (s1_yb),
      .in_end_xa (s1_end_xa),
      .in_end_ya (s1_end_ya),
      .in_end_xb (s1_end_xb),
      .in_end_yb (s1_end_yb),
      .in_rad    (s1_rad),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_ctl   (s2_ctl),
      .out_mag_x (s2_mag_x),
      .out_mag_y (s2_mag_y),
      .out_rad   (s2_rad)
   );

   rcc_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_ctl    (s2_ctl),
      .in_mag_x  (s2_mag_x),
      .in_mag_y  (s2_mag_y),
      .in_rad    (s2_rad),
      .out_valid (s3_valid),
      .out_stall (s3_stall),
      .out_ctl   (s3_ctl),
      .out_sq_x  (s3_sq_x),
      .out_sq_y  (s3_sq_y),
      .out_sq_r  (s3_sq_r)
   );

   rcc_compare #(.COORD_BITS(COORD_BITS)) u_compare (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_stall  (s3_stall),
      .in_ctl    (s3_ctl),
      .in_sq_x   (s3_sq_x),
      .in_sq_y   (s3_sq_y),
      .in_sq_r   (s3_sq_r),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_hit   (rsp_hit)
   );

endmodule

// ===== sv/rcc_checker.sv =====
// Port-level checks for the collision test block, bound to its top level.
// Depends on rcc_pkg; attaches to rect_circle_collision_test.
module rcc_checker import rcc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [LAYER_BITS-1:0]   req_layers_a,
   input logic [LAYER_BITS-1:0]   req_layers_b,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic                    rsp_hit
);

   logic req_xfer;
   logic layer_miss;

   assign req_xfer   = req_valid && !req_stall;
   assign layer_miss = ((req_layers_a & req_layers_b) == '0) && (req_layers_a != req_layers_b);

   // Nothing is shown in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit))
      else $error("stalled response changed");

   // Back-pressure reaches the request side only with a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // With no stall, a pair on disjoint layers yields a response that misses
   a_layer_miss: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && layer_miss) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid && !rsp_hit)
      else $error("disjoint layers reported a hit or response late");

endmodule

bind rect_circle_collision_test rcc_checker u_rcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_layers_a (req_layers_a),
   .req_layers_b (req_layers_b),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_hit      (rsp_hit)
);
